### sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared types and constants for the brake light sequencer
// ----------------------------------------------------------------------------
package bls_pkg;

    // sequence phases, one-hot
    typedef enum logic [6:0] {
        PH_START         = 7'b000_0001,
        PH_FAILSAFE_WAIT = 7'b000_0010,
        PH_REMIND_WAIT   = 7'b000_0100,
        PH_GAP_WAIT      = 7'b000_1000,
        PH_BRAKE_WAIT    = 7'b001_0000,
        PH_ATTN_WAIT     = 7'b010_0000,
        PH_RELEASE_WAIT  = 7'b100_0000
    } phase_t;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_FAILSAFE_PERIOD      = 3'd0;
    localparam logic [2:0] REG_REMINDER_FLASH_TIME  = 3'd1;
    localparam logic [2:0] REG_REMINDER_GAP         = 3'd2;
    localparam logic [2:0] REG_ATTENTION_FLASH_TIME = 3'd3;
    localparam logic [2:0] REG_ATTENTION_REST_TIME  = 3'd4;
    localparam logic [2:0] REG_ATTENTION_PAIRS      = 3'd5;
    localparam logic [2:0] REG_DIM_LEVEL            = 3'd6;
    localparam logic [2:0] REG_BRIGHT_LEVEL         = 3'd7;

    // register reset values
    localparam logic [15:0] RST_FAILSAFE_PERIOD      = 16'd500;
    localparam logic [15:0] RST_REMINDER_FLASH_TIME  = 16'd100;
    localparam logic [15:0] RST_REMINDER_GAP         = 16'd4000;
    localparam logic [15:0] RST_ATTENTION_FLASH_TIME = 16'd100;
    localparam logic [23:0] RST_ATTENTION_REST_TIME  = 24'd30000;
    localparam logic [6:0]  RST_ATTENTION_PAIRS      = 7'd3;
    localparam logic [7:0]  RST_DIM_LEVEL            = 8'd64;
    localparam logic [7:0]  RST_BRIGHT_LEVEL         = 8'd255;

    localparam logic [7:0]  LEVEL_FULL = 8'd255;
    localparam logic [7:0]  LEVEL_OFF  = 8'd0;

endpackage

### sv/brake_light_sequencer_unit.sv
// ----------------------------------------------------------------------------
// brake_light_sequencer_unit
// tick-driven left/right brake lamp sequencer with an APB register port
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick carrying the link-lost, engine-on,
// brake-pressed and lamps-requested flags; each tick yields exactly one output
// transaction with the left and right lamp levels (255 is full on). One tick
// is accepted every clock cycle while no result waits on m_ready: the tick is
// captured in an input register and the whole sequence step (both down-counters,
// then every phase change the tick causes) is resolved by the step logic into
// the lamp registers; throughput is then one tick per cycle. While a finished
// result still waits on m_ready, the input register takes one more tick only if
// it is empty and then stalls. Registers live on a 32-bit APB port at byte
// address 4*index and should only be written while no tick is in flight. There
// is no start-up clearing pass; the block is ready straight after reset.
// ----------------------------------------------------------------------------
module brake_light_sequencer_unit
    import bls_pkg::*;
#(
    parameter int PERIOD_BITS = 16,
    parameter int REST_BITS   = 24
) (
    input  logic        aclk,
    input  logic        aresetn,

    // tick input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_link_lost,
    input  logic        s_engine_on,
    input  logic        s_brake_pressed,
    input  logic        s_lamps_requested,

    // lamp level output channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_left_level,
    output logic [7:0]  m_right_level,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [15:0] failsafe_period_reg;
    logic [15:0] reminder_flash_time_reg;
    logic [15:0] reminder_gap_reg;
    logic [15:0] attention_flash_time_reg;
    logic [23:0] attention_rest_time_reg;
    logic [6:0]  attention_pairs_reg;
    logic [7:0]  dim_level_reg;
    logic [7:0]  bright_level_reg;

    // input register
    logic in_valid_reg;
    logic link_lost_reg;
    logic engine_on_reg;
    logic brake_pressed_reg;
    logic lamps_requested_reg;

    // sequence state; the lamp holds double as the result register
    phase_t                 phase_reg,       phase_next;
    logic                   flash_side_reg,  flash_side_next;
    logic [7:0]             flash_cnt_reg,   flash_cnt_next;
    logic [7:0]             chosen_reg,      chosen_next;
    logic [PERIOD_BITS-1:0] flash_rem_reg,   flash_rem_next;
    logic [REST_BITS-1:0]   idle_rem_reg,    idle_rem_next;
    logic [7:0]             left_hold_reg,   left_hold_next;
    logic [7:0]             right_hold_reg,  right_hold_next;
    logic                   out_valid_reg;

    logic        advance;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [7:0]  pairs_x2;
    logic [31:0] rest_ext;

    // a period of zero after masking counts as one tick
    function automatic logic [PERIOD_BITS-1:0] period_load(input logic [15:0] v);
        logic [31:0]            ext;
        logic [PERIOD_BITS-1:0] p;
        ext = {16'b0, v};
        p   = ext[PERIOD_BITS-1:0];
        if (p == '0) begin
            p = PERIOD_BITS'(1);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // handshake: the step runs when a tick is held and the result slot is free or taken
    // ------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_left_level  = left_hold_reg;
    assign m_right_level = right_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tick payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            link_lost_reg       <= s_link_lost;
            engine_on_reg       <= s_engine_on;
            brake_pressed_reg   <= s_brake_pressed;
            lamps_requested_reg <= s_lamps_requested;
        end
    end

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failsafe_period_reg      <= RST_FAILSAFE_PERIOD;
            reminder_flash_time_reg  <= RST_REMINDER_FLASH_TIME;
            reminder_gap_reg         <= RST_REMINDER_GAP;
            attention_flash_time_reg <= RST_ATTENTION_FLASH_TIME;
            attention_rest_time_reg  <= RST_ATTENTION_REST_TIME;
            attention_pairs_reg      <= RST_ATTENTION_PAIRS;
            dim_level_reg            <= RST_DIM_LEVEL;
            bright_level_reg         <= RST_BRIGHT_LEVEL;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_FAILSAFE_PERIOD:      failsafe_period_reg      <= pwdata[15:0];
                REG_REMINDER_FLASH_TIME:  reminder_flash_time_reg  <= pwdata[15:0];
                REG_REMINDER_GAP:         reminder_gap_reg         <= pwdata[15:0];
                REG_ATTENTION_FLASH_TIME: attention_flash_time_reg <= pwdata[15:0];
                REG_ATTENTION_REST_TIME:  attention_rest_time_reg  <= pwdata[23:0];
                REG_ATTENTION_PAIRS:      attention_pairs_reg      <= pwdata[6:0];
                REG_DIM_LEVEL:            dim_level_reg            <= pwdata[7:0];
                REG_BRIGHT_LEVEL:         bright_level_reg         <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_FAILSAFE_PERIOD:      prdata = {16'b0, failsafe_period_reg};
            REG_REMINDER_FLASH_TIME:  prdata = {16'b0, reminder_flash_time_reg};
            REG_REMINDER_GAP:         prdata = {16'b0, reminder_gap_reg};
            REG_ATTENTION_FLASH_TIME: prdata = {16'b0, attention_flash_time_reg};
            REG_ATTENTION_REST_TIME:  prdata = {8'b0, attention_rest_time_reg};
            REG_ATTENTION_PAIRS:      prdata = {25'b0, attention_pairs_reg};
            REG_DIM_LEVEL:            prdata = {24'b0, dim_level_reg};
            REG_BRIGHT_LEVEL:         prdata = {24'b0, bright_level_reg};
            default:                  prdata = 32'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequence step: counters tick down, then the phases settle in order
    // link test -> engine check -> brake test -> attention test -> release test
    // ------------------------------------------------------------------
    assign pairs_x2 = {attention_pairs_reg, 1'b0};
    assign rest_ext = {8'b0, attention_rest_time_reg};

    always_comb begin
        logic do_engine;
        logic do_brake;
        logic do_attn;
        logic do_release;

        do_engine  = 1'b0;
        do_brake   = 1'b0;
        do_attn    = 1'b0;
        do_release = 1'b0;

        phase_next      = phase_reg;
        flash_side_next = flash_side_reg;
        flash_cnt_next  = flash_cnt_reg;
        chosen_next     = chosen_reg;
        left_hold_next  = left_hold_reg;
        right_hold_next = right_hold_reg;

        // both down-counters stop at zero
        flash_rem_next = (flash_rem_reg != '0) ? flash_rem_reg - PERIOD_BITS'(1)
                                               : flash_rem_reg;
        idle_rem_next  = (idle_rem_reg != '0) ? idle_rem_reg - REST_BITS'(1)
                                              : idle_rem_reg;

        case (phase_reg)
            PH_FAILSAFE_WAIT: begin
                if (flash_rem_next == '0) begin
                    if (link_lost_reg) begin
                        left_hold_next  = flash_side_reg ? LEVEL_FULL : LEVEL_OFF;
                        right_hold_next = flash_side_reg ? LEVEL_OFF : LEVEL_FULL;
                        flash_side_next = !flash_side_reg;
                        flash_rem_next  = period_load(failsafe_period_reg);
                        phase_next      = PH_FAILSAFE_WAIT;
                    end else begin
                        do_engine = 1'b1;
                    end
                end
            end
            PH_REMIND_WAIT: begin
                if (flash_rem_next == '0) begin
                    if (flash_side_reg) begin
                        // right flash done, go dark for the gap
                        right_hold_next = LEVEL_OFF;
                        flash_rem_next  = period_load(reminder_gap_reg);
                        phase_next      = PH_GAP_WAIT;
                    end else begin
                        do_engine = 1'b1;
                    end
                end
            end
            PH_GAP_WAIT: begin
                if (flash_rem_next == '0) begin
                    do_engine = 1'b1;
                end
            end
            PH_BRAKE_WAIT: begin
                do_brake = 1'b1;
            end
            PH_ATTN_WAIT: begin
                if (flash_rem_next == '0) begin
                    flash_cnt_next = flash_cnt_reg + 8'd1;
                    do_attn        = 1'b1;
                end
            end
            PH_RELEASE_WAIT: begin
                do_release = 1'b1;
            end
            default: begin
                // start of sequence: link test with no wait
                if (link_lost_reg) begin
                    left_hold_next  = flash_side_reg ? LEVEL_FULL : LEVEL_OFF;
                    right_hold_next = flash_side_reg ? LEVEL_OFF : LEVEL_FULL;
                    flash_side_next = !flash_side_reg;
                    flash_rem_next  = period_load(failsafe_period_reg);
                    phase_next      = PH_FAILSAFE_WAIT;
                end else begin
                    do_engine = 1'b1;
                end
            end
        endcase

        // engine-off reminder or fall through to the brake wait
        if (do_engine) begin
            if (!engine_on_reg) begin
                left_hold_next  = flash_side_next ? LEVEL_FULL : LEVEL_OFF;
                right_hold_next = flash_side_next ? LEVEL_OFF : LEVEL_FULL;
                flash_side_next = !flash_side_next;
                flash_rem_next  = period_load(reminder_flash_time_reg);
                phase_next      = PH_REMIND_WAIT;
            end else begin
                left_hold_next  = LEVEL_OFF;
                right_hold_next = LEVEL_OFF;
                phase_next      = PH_BRAKE_WAIT;
                do_brake        = 1'b1;
            end
        end

        // brake press picks the level and arms or skips the burst
        if (do_brake && brake_pressed_reg) begin
            chosen_next = lamps_requested_reg ? dim_level_reg : bright_level_reg;
            if (idle_rem_next == '0) begin
                flash_side_next = 1'b0;
                flash_cnt_next  = 8'd0;
            end else begin
                flash_cnt_next  = pairs_x2;
            end
            do_attn = 1'b1;
        end

        // next attention step or steady on
        if (do_attn) begin
            if (flash_cnt_next < pairs_x2) begin
                left_hold_next  = flash_side_next ? chosen_next : LEVEL_OFF;
                right_hold_next = flash_side_next ? LEVEL_OFF : chosen_next;
                flash_side_next = !flash_side_next;
                flash_rem_next  = period_load(attention_flash_time_reg);
                phase_next      = PH_ATTN_WAIT;
            end else begin
                left_hold_next  = chosen_next;
                right_hold_next = chosen_next;
                phase_next      = PH_RELEASE_WAIT;
                do_release      = 1'b1;
            end
        end

        // release re-arms the idle timer and restarts on the next tick
        if (do_release && !brake_pressed_reg) begin
            idle_rem_next = rest_ext[REST_BITS-1:0];
            phase_next    = PH_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            flash_side_reg <= 1'b0;
            flash_cnt_reg  <= 8'd0;
            chosen_reg     <= 8'd0;
            flash_rem_reg  <= '0;
            idle_rem_reg   <= '0;
            left_hold_reg  <= 8'd0;
            right_hold_reg <= 8'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            flash_side_reg <= flash_side_next;
            flash_cnt_reg  <= flash_cnt_next;
            chosen_reg     <= chosen_next;
            flash_rem_reg  <= flash_rem_next;
            idle_rem_reg   <= idle_rem_next;
            left_hold_reg  <= left_hold_next;
            right_hold_reg <= right_hold_next;
        end
    end

`ifndef SYNTHESIS
    // a timed wait is never entered with an empty counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FAILSAFE_WAIT || phase_reg == PH_REMIND_WAIT ||
         phase_reg == PH_GAP_WAIT || phase_reg == PH_ATTN_WAIT) |-> (flash_rem_reg != '0))
        else $error("timed wait with zero flash counter");

    // steady on shows the chosen level on both lamps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RELEASE_WAIT) |->
            (left_hold_reg == chosen_reg && right_hold_reg == chosen_reg))
        else $error("steady on lamps differ from chosen level");

    // failsafe flashing is always one lamp full, the other dark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FAILSAFE_WAIT) |->
            (left_hold_reg != right_hold_reg &&
             (left_hold_reg == LEVEL_FULL || right_hold_reg == LEVEL_FULL)))
        else $error("failsafe lamps not alternating");

    // a release transaction re-arms the idle timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_RELEASE_WAIT && !brake_pressed_reg) |=>
            (phase_reg == PH_START && idle_rem_reg == rest_ext[REST_BITS-1:0]))
        else $error("release did not re-arm idle timer");

    // a captured tick always produces a result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("tick dropped between input and result register");
`endif

endmodule
